FILE: rtl/apnt_pkg.sv
// shared types and constants of the affine point and normal transform
package apnt_pkg;

	localparam int CoefW   = 20;
	localparam int RowW    = 3 * CoefW;
	localparam int PointW  = 32;
	localparam int NormW   = 16;
	localparam int CofW    = 41;
	localparam int PpW     = CoefW + PointW;
	localparam int PnW     = CofW + NormW;
	localparam int MagW    = PnW + 1;
	localparam int NormFW  = 30;
	localparam int SqW     = 2 * NormFW;
	localparam int SumSqW  = SqW + 2;
	localparam int RootW   = SumSqW / 2;
	localparam int QuotW   = 16;
	localparam int NumW    = NormFW + 14 + 1;

	localparam logic [2:0] REG_ROW_X = 3'd0;
	localparam logic [2:0] REG_ROW_Y = 3'd1;
	localparam logic [2:0] REG_ROW_Z = 3'd2;
	localparam logic [2:0] REG_OFF_X = 3'd3;
	localparam logic [2:0] REG_OFF_Y = 3'd4;
	localparam logic [2:0] REG_OFF_Z = 3'd5;

	// pipeline stage positions
	localparam int StProd   = 0;
	localparam int StSum    = 1;
	localparam int StMag    = 2;
	localparam int StMsb    = 3;
	localparam int StNorm   = 4;
	localparam int StSq     = 5;
	localparam int StSumSq  = 6;
	localparam int StSqrt0  = 7;
	localparam int StSqrtN  = StSqrt0 + RootW - 1;
	localparam int StDivIn  = StSqrtN + 1;
	localparam int StDiv0   = StDivIn + 1;
	localparam int StDivN   = StDiv0 + QuotW - 1;
	localparam int StLast   = StDivN + 1;

	localparam int Next1[3] = '{1, 2, 0};
	localparam int Next2[3] = '{2, 0, 1};

	typedef struct packed {
		logic                        pok;
		logic                        nok;
		logic                        nzero;
		logic                        kept;
		logic [2:0][PointW-1:0]      p;
		logic [2:0][NormW-1:0]       n;
		logic [8:0][PpW-1:0]         pp;
		logic [8:0][PnW-1:0]         pn;
		logic [2:0][PpW+1:0]         psum;
		logic [2:0][PnW+1:0]         tsum;
		logic [2:0]                  neg;
		logic [2:0][MagW-1:0]        mag;
		logic [5:0]                  msb;
		logic [2:0][NormFW-1:0]      m30;
		logic [2:0][SqW-1:0]         sq;
		logic [SumSqW-1:0]           s;
		logic [RootW+1:0]            rem;
		logic [RootW-1:0]            root;
		logic [2:0][NumW-1:0]        num;
		logic [2:0][RootW:0]         drem;
		logic [2:0][QuotW-1:0]       q;
		logic [2:0][PointW-1:0]      moved;
		logic [2:0][NormW-1:0]       unit;
	} apnt_pipe_t;

endpackage

FILE: rtl/affine_point_normal_transform_core.sv
// affine point and normal transform core, one item per clock when not stalled or held off
// Maps each point by the configured 3x3 linear part plus offset and each normal by the signed
// cofactor matrix, renormalised to unit length. One request is taken per cycle unless the output stalls or
// the input is held off; the depth is set by the one-bit-per-stage square root (31 stages) and the
// one-bit-per-stage divider (16 stages). After reset and after a register write the input is held
// off while the cofactors and determinant settle.
module affine_point_normal_transform_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [143:0] s_axis_tdata,  // point_x, point_y, point_z, normal_x, normal_y, normal_z
	input  logic [1:0]   s_axis_tuser,  // point_ok, normal_ok
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [143:0] m_axis_tdata,  // moved_x, moved_y, moved_z, unit_x, unit_y, unit_z
	output logic [2:0]   m_axis_tuser,  // moved_ok, unit_ok, normal_kept
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [59:0]  cfg_data
);

	localparam int Last = apnt_pkg::StLast;

	logic [2:0][apnt_pkg::RowW-1:0]   row_q;
	logic [2:0][apnt_pkg::PointW-1:0] off_q;
	logic [8:0][apnt_pkg::CofW-1:0]   cof_q;
	logic [2:0][61:0]                 dp_q;
	logic                             det_neg_q;
	logic                             det_zero_q;
	logic [1:0]                       hold_q;

	apnt_pkg::apnt_pipe_t st [Last+1];
	apnt_pkg::apnt_pipe_t nxt [Last+1];
	logic [Last:0]        v_q;
	logic [Last:0]        en;
	logic                 accept;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0] <= 60'd32768;
			row_q[1] <= 60'd32768 << 20;
			row_q[2] <= 60'd32768 << 40;
			off_q    <= '0;
			hold_q   <= 2'd2;
		end else begin
			if (cfg_we) begin
				hold_q <= 2'd2;
				case (cfg_index)
					apnt_pkg::REG_ROW_X: row_q[0] <= cfg_data;
					apnt_pkg::REG_ROW_Y: row_q[1] <= cfg_data;
					apnt_pkg::REG_ROW_Z: row_q[2] <= cfg_data;
					apnt_pkg::REG_OFF_X: off_q[0] <= cfg_data[31:0];
					apnt_pkg::REG_OFF_Y: off_q[1] <= cfg_data[31:0];
					apnt_pkg::REG_OFF_Z: off_q[2] <= cfg_data[31:0];
					default: ;
				endcase
			end else if (hold_q != 2'd0) begin
				hold_q <= hold_q - 2'd1;
			end
		end
	end

	// cofactors, determinant sign and determinant zero flag
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				cof_q[3*i+j] <=
					41'($signed(row_q[apnt_pkg::Next1[i]][20*apnt_pkg::Next1[j] +: 20])
					  * $signed(row_q[apnt_pkg::Next2[i]][20*apnt_pkg::Next2[j] +: 20]))
					- 41'($signed(row_q[apnt_pkg::Next1[i]][20*apnt_pkg::Next2[j] +: 20])
					  * $signed(row_q[apnt_pkg::Next2[i]][20*apnt_pkg::Next1[j] +: 20]));
			end
			dp_q[i] <= 62'($signed(row_q[0][20*i +: 20]) * $signed(cof_q[i]));
		end
		det_neg_q  <= (64'($signed(dp_q[0])) + 64'($signed(dp_q[1]))
		               + 64'($signed(dp_q[2]))) < 0 ? 1'b1 : 1'b0;
		det_zero_q <= (64'($signed(dp_q[0])) + 64'($signed(dp_q[1]))
		               + 64'($signed(dp_q[2]))) == 64'sd0;
	end

	always_comb begin
		en[Last] = !v_q[Last] || m_axis_tready;
		for (int k = Last - 1; k >= 0; k--) begin
			en[k] = !v_q[k] || en[k+1];
		end
	end

	assign s_axis_tready = en[0] && (hold_q == 2'd0);
	assign accept        = s_axis_tvalid && s_axis_tready;

	// stage logic
	always_comb begin
		logic signed [38:0] rsh;
		logic signed [39:0] rr;
		logic signed [58:0] tn;
		logic [34:0]        r4;
		logic [34:0]        trial;
		logic [31:0]        r2;
		logic [15:0]        qs;
		logic [57:0]        ormag;
		int                 sb;
		int                 qb;
		nxt[0] = '0;
		for (int k = 1; k <= Last; k++) begin
			nxt[k] = st[k-1];
		end
		rsh = '0; rr = '0; tn = '0; r4 = '0; trial = '0; r2 = '0; qs = '0; ormag = '0;
		sb = 0; qb = 0;

		// products
		nxt[0].pok = s_axis_tuser[0];
		nxt[0].nok = s_axis_tuser[1];
		for (int j = 0; j < 3; j++) begin
			nxt[0].p[j] = s_axis_tdata[32*j +: 32];
			nxt[0].n[j] = s_axis_tdata[96 + 16*j +: 16];
		end
		nxt[0].nzero = (s_axis_tdata[143:96] == 48'd0);
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				nxt[0].pp[3*i+j] = 52'($signed(row_q[i][20*j +: 20])
				                     * $signed(s_axis_tdata[32*j +: 32]));
				nxt[0].pn[3*i+j] = 57'($signed(cof_q[3*i+j])
				                     * $signed(s_axis_tdata[96 + 16*j +: 16]));
			end
		end

		// row sums
		for (int i = 0; i < 3; i++) begin
			nxt[apnt_pkg::StSum].psum[i] = 54'($signed(st[0].pp[3*i])) + 54'($signed(st[0].pp[3*i+1]))
			                             + 54'($signed(st[0].pp[3*i+2]));
			nxt[apnt_pkg::StSum].tsum[i] = 59'($signed(st[0].pn[3*i])) + 59'($signed(st[0].pn[3*i+1]))
			                             + 59'($signed(st[0].pn[3*i+2]));
		end

		// point rounding and offset, normal magnitudes
		for (int i = 0; i < 3; i++) begin
			rsh = 39'(($signed(st[apnt_pkg::StSum].psum[i]) + 54'sd16384) >>> 15);
			rr  = 40'(rsh) + 40'($signed(off_q[i]));
			if (!st[apnt_pkg::StSum].pok)
				nxt[apnt_pkg::StMag].moved[i] = st[apnt_pkg::StSum].p[i];
			else if (rr > 40'sd2147483647)
				nxt[apnt_pkg::StMag].moved[i] = 32'h7fffffff;
			else if (rr < -40'sd2147483648)
				nxt[apnt_pkg::StMag].moved[i] = 32'h80000000;
			else
				nxt[apnt_pkg::StMag].moved[i] = rr[31:0];
			tn = det_neg_q ? -$signed(st[apnt_pkg::StSum].tsum[i])
			               : $signed(st[apnt_pkg::StSum].tsum[i]);
			nxt[apnt_pkg::StMag].neg[i] = tn[58];
			nxt[apnt_pkg::StMag].mag[i] = tn[58] ? 58'(-tn) : tn[57:0];
		end
		nxt[apnt_pkg::StMag].kept = st[apnt_pkg::StSum].nok
		                          && (det_zero_q || st[apnt_pkg::StSum].nzero);

		// leading one of the largest magnitude
		ormag = st[apnt_pkg::StMag].mag[0] | st[apnt_pkg::StMag].mag[1]
		      | st[apnt_pkg::StMag].mag[2];
		nxt[apnt_pkg::StMsb].msb = '0;
		for (int b = 0; b < 58; b++) begin
			if (ormag[b])
				nxt[apnt_pkg::StMsb].msb = 6'(b);
		end

		// bring the largest into [2^29, 2^30)
		for (int i = 0; i < 3; i++) begin
			if (st[apnt_pkg::StMsb].msb >= 6'd29)
				nxt[apnt_pkg::StNorm].m30[i] = 30'(st[apnt_pkg::StMsb].mag[i]
				                               >> (st[apnt_pkg::StMsb].msb - 6'd29));
			else
				nxt[apnt_pkg::StNorm].m30[i] = 30'(st[apnt_pkg::StMsb].mag[i]
				                               << (6'd29 - st[apnt_pkg::StMsb].msb));
		end

		for (int i = 0; i < 3; i++) begin
			nxt[apnt_pkg::StSq].sq[i] = 60'(st[apnt_pkg::StNorm].m30[i])
			                          * 60'(st[apnt_pkg::StNorm].m30[i]);
		end

		nxt[apnt_pkg::StSumSq].s = 62'(st[apnt_pkg::StSq].sq[0]) + 62'(st[apnt_pkg::StSq].sq[1])
		                         + 62'(st[apnt_pkg::StSq].sq[2]);
		nxt[apnt_pkg::StSumSq].rem  = '0;
		nxt[apnt_pkg::StSumSq].root = '0;

		// square root, one result bit per stage
		for (int k = apnt_pkg::StSqrt0; k <= apnt_pkg::StSqrtN; k++) begin
			sb    = apnt_pkg::StSqrtN - k;
			r4    = {st[k-1].rem, st[k-1].s[2*sb+1 -: 2]};
			trial = {2'b00, st[k-1].root, 2'b01};
			if (r4 >= trial) begin
				nxt[k].rem  = 33'(r4 - trial);
				nxt[k].root = {st[k-1].root[29:0], 1'b1};
			end else begin
				nxt[k].rem  = r4[32:0];
				nxt[k].root = {st[k-1].root[29:0], 1'b0};
			end
		end

		// dividend with half-length rounding term
		for (int i = 0; i < 3; i++) begin
			nxt[apnt_pkg::StDivIn].num[i] = {1'b0, st[apnt_pkg::StSqrtN].m30[i], 14'd0}
			                              + 45'(st[apnt_pkg::StSqrtN].root >> 1);
			nxt[apnt_pkg::StDivIn].drem[i] = 32'(nxt[apnt_pkg::StDivIn].num[i][44:16]);
			nxt[apnt_pkg::StDivIn].q[i]    = '0;
		end

		// restoring division, one quotient bit per stage
		for (int k = apnt_pkg::StDiv0; k <= apnt_pkg::StDivN; k++) begin
			qb = apnt_pkg::StDivN - k;
			for (int i = 0; i < 3; i++) begin
				r2 = {st[k-1].drem[i][30:0], st[k-1].num[i][qb]};
				if (r2 >= {1'b0, st[k-1].root}) begin
					nxt[k].drem[i]  = r2 - {1'b0, st[k-1].root};
					nxt[k].q[i][qb] = 1'b1;
				end else begin
					nxt[k].drem[i]  = r2;
					nxt[k].q[i][qb] = 1'b0;
				end
			end
		end

		// saturate, sign and select
		for (int i = 0; i < 3; i++) begin
			qs = st[apnt_pkg::StDivN].q[i][15] ? 16'd32767 : st[apnt_pkg::StDivN].q[i];
			if (!st[apnt_pkg::StDivN].nok || st[apnt_pkg::StDivN].kept)
				nxt[Last].unit[i] = st[apnt_pkg::StDivN].n[i];
			else
				nxt[Last].unit[i] = st[apnt_pkg::StDivN].neg[i] ? 16'(-qs) : qs;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0])
				v_q[0] <= accept;
			for (int k = 1; k <= Last; k++) begin
				if (en[k])
					v_q[k] <= v_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k <= Last; k++) begin
			if (en[k])
				st[k] <= nxt[k];
		end
	end

	assign m_axis_tvalid = v_q[Last];
	assign m_axis_tdata  = {st[Last].unit[2], st[Last].unit[1], st[Last].unit[0],
	                        st[Last].moved[2], st[Last].moved[1], st[Last].moved[0]};
	assign m_axis_tuser  = {st[Last].kept, st[Last].nok, st[Last].pok};

`ifndef SYNTHESIS
	a_hold_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !s_axis_tready)
		else $error("request taken right after register write");
	a_kept_needs_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tuser[1])
		else $error("normal kept on invalid normal");
	a_root_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[apnt_pkg::StSqrtN] && st[apnt_pkg::StSqrtN].nok && !st[apnt_pkg::StSqrtN].kept
		|-> st[apnt_pkg::StSqrtN].root[30:29] != 2'b00)
		else $error("normal length out of range");
	a_valid_moves: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> v_q[0])
		else $error("accepted request lost at entry");
`endif

endmodule

FILE: bench/tb_affine_point_normal_transform_core.sv
// self-checking bench for the affine point and normal transform core
`timescale 1ns / 100ps

module tb_affine_point_normal_transform_core;

	typedef struct packed {
		logic [2:0][31:0] pt;
		logic             pok;
		logic [2:0][15:0] nm;
		logic             nok;
	} xform_req_t;

	typedef struct packed {
		logic [2:0][31:0] moved;
		logic             mok;
		logic [2:0][15:0] unit;
		logic             uok;
		logic             kept;
	} xform_res_t;

	localparam int Latency = 60;
	localparam longint CycleLimit = 400000;
	localparam logic [2:0] RegSpareA = 3'd6;
	localparam logic [2:0] RegSpareB = 3'd7;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [143:0] s_axis_tdata;
	logic [1:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [143:0] m_axis_tdata;
	logic [2:0]   m_axis_tuser;
	logic         cfg_we;
	logic [2:0]   cfg_index;
	logic [59:0]  cfg_data;

	longint lin[3][3];
	longint offs[3];
	xform_res_t expected_q[$];
	int errors;
	longint cycles;
	int send_idle_pct;
	int recv_idle_pct;
	bit recv_hold;

	affine_point_normal_transform_core dut (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic longint sx(input logic [63:0] v, input int w);
		longint r;
		r = v & ((64'd1 << w) - 1);
		if (r[w-1]) r = r - (longint'(1) << w);
		return r;
	endfunction

	function automatic longint floor_shr(input longint x, input int k);
		if (x >= 0) return x >>> k;
		return -(((-x) - 1) >>> k) - 1;
	endfunction

	function automatic longint int_sqrt(input longint unsigned s);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > s) b >>= 2;
		while (b != 0) begin
			if (s >= r + b) begin
				s -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	function automatic xform_res_t transform(input xform_req_t rq);
		xform_res_t rs;
		longint p[3], n[3], c[3][3], t[3], det, r, acc, q;
		longint unsigned mag[3], mx, s, len;
		rs = '0;
		for (int i = 0; i < 3; i++) begin
			p[i] = sx(rq.pt[i], 32);
			n[i] = sx(rq.nm[i], 16);
		end
		for (int i = 0; i < 3; i++) begin
			r = p[i];
			if (rq.pok) begin
				acc = lin[i][0] * p[0] + lin[i][1] * p[1] + lin[i][2] * p[2];
				r = floor_shr(acc + 16384, 15) + offs[i];
				if (r > 64'sd2147483647) r = 64'sd2147483647;
				if (r < -64'sd2147483648) r = -64'sd2147483648;
			end
			rs.moved[i] = r[31:0];
			rs.unit[i] = rq.nm[i];
		end
		rs.mok = rq.pok;
		rs.uok = rq.nok;
		if (rq.nok) begin
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					c[i][j] = lin[(i+1)%3][(j+1)%3] * lin[(i+2)%3][(j+2)%3]
						- lin[(i+1)%3][(j+2)%3] * lin[(i+2)%3][(j+1)%3];
			det = lin[0][0] * c[0][0] + lin[0][1] * c[0][1] + lin[0][2] * c[0][2];
			if (det == 0 || (n[0] == 0 && n[1] == 0 && n[2] == 0))
				rs.kept = 1'b1;
			else begin
				for (int i = 0; i < 3; i++) begin
					t[i] = c[i][0] * n[0] + c[i][1] * n[1] + c[i][2] * n[2];
					if (det < 0) t[i] = -t[i];
					mag[i] = t[i] < 0 ? -t[i] : t[i];
				end
				mx = mag[0];
				if (mag[1] > mx) mx = mag[1];
				if (mag[2] > mx) mx = mag[2];
				while (mx >= (64'd1 << 30)) begin
					mx >>= 1;
					for (int i = 0; i < 3; i++) mag[i] >>= 1;
				end
				while (mx < (64'd1 << 29)) begin
					mx <<= 1;
					for (int i = 0; i < 3; i++) mag[i] <<= 1;
				end
				s = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
				len = int_sqrt(s);
				for (int i = 0; i < 3; i++) begin
					q = (mag[i] * 16384 + len / 2) / len;
					if (q > 32767) q = 32767;
					if (t[i] < 0) q = -q;
					rs.unit[i] = q[15:0];
				end
			end
		end
		return rs;
	endfunction

	task automatic report(input string what, input longint got, input longint want);
		errors++;
		$display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
	endtask

	// result checker
	always @(posedge clk) begin
		xform_res_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.moved = m_axis_tdata[95:0];
			got.unit = m_axis_tdata[143:96];
			got.mok = m_axis_tuser[0];
			got.uok = m_axis_tuser[1];
			got.kept = m_axis_tuser[2];
			if (expected_q.size() == 0)
				report("unexpected result", m_axis_tdata[31:0], 0);
			else begin
				want = expected_q.pop_front();
				for (int i = 0; i < 3; i++) begin
					if (got.moved[i] !== want.moved[i])
						report($sformatf("moved[%0d]", i), got.moved[i], want.moved[i]);
					if (got.unit[i] !== want.unit[i])
						report($sformatf("unit[%0d]", i), got.unit[i], want.unit[i]);
				end
				if (got.mok !== want.mok) report("moved_ok", got.mok, want.mok);
				if (got.uok !== want.uok) report("unit_ok", got.uok, want.uok);
				if (got.kept !== want.kept) report("normal_kept", got.kept, want.kept);
			end
		end
	end

	// receiver stalls
	always @(negedge clk) begin
		if (recv_hold)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic send_request(input xform_req_t rq);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tdata <= {rq.nm, rq.pt};
		s_axis_tuser <= {rq.nok, rq.pok};
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		expected_q.push_back(transform(rq));
		@(negedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(negedge clk);
		repeat (Latency) @(negedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [59:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		if (idx <= apnt_pkg::REG_ROW_Z)
			for (int j = 0; j < 3; j++) lin[idx][j] = sx(val >> (20 * j), 20);
		else if (idx <= apnt_pkg::REG_OFF_Z)
			offs[idx - apnt_pkg::REG_OFF_X] = sx(val, 32);
	endtask

	function automatic logic [19:0] rand_coef();
		case ($urandom_range(5))
			0: return 20'h80000;
			1: return 20'h7ffff;
			2: return 20'h08000;
			3: return 20'($urandom_range(65535) - 32768);
			default: return 20'($urandom);
		endcase
	endfunction

	function automatic xform_req_t rand_req();
		xform_req_t rq;
		for (int i = 0; i < 3; i++) begin
			case ($urandom_range(5))
				0: rq.pt[i] = 32'h80000000;
				1: rq.pt[i] = 32'h7fffffff;
				2: rq.pt[i] = $urandom_range(65535) - 32768;
				default: rq.pt[i] = $urandom;
			endcase
			case ($urandom_range(5))
				0: rq.nm[i] = 16'h8000;
				1: rq.nm[i] = 16'h7fff;
				2: rq.nm[i] = 16'h0000;
				default: rq.nm[i] = 16'($urandom);
			endcase
		end
		if ($urandom_range(9) == 0) rq.nm = '0;
		rq.pok = ($urandom_range(9) != 0);
		rq.nok = ($urandom_range(9) != 0);
		return rq;
	endfunction

	task automatic random_matrix();
		for (int r = 0; r < 3; r++)
			write_reg(3'(apnt_pkg::REG_ROW_X + r), {rand_coef(), rand_coef(), rand_coef()});
		for (int r = 0; r < 3; r++)
			write_reg(3'(apnt_pkg::REG_OFF_X + r), 60'($urandom));
	endtask

	task automatic test_identity_corners();
		xform_req_t rq;
		logic [31:0] pv[4] = '{32'h80000000, 32'h7fffffff, 32'h0, 32'h00001000};
		logic [15:0] nv[4] = '{16'h8000, 16'h7fff, 16'h0, 16'h4000};
		for (int k = 0; k < 12; k++) begin
			for (int i = 0; i < 3; i++) begin
				rq.pt[i] = pv[(k + i) % 4];
				rq.nm[i] = nv[(k + 2 * i) % 4];
			end
			rq.pok = k[0];
			rq.nok = (k % 3 != 0);
			send_request(rq);
		end
		rq = '0;
		rq.pok = 1'b1;
		rq.nok = 1'b1;
		send_request(rq);
		drain();
	endtask

	task automatic test_extreme_matrix();
		xform_req_t rq;
		write_reg(apnt_pkg::REG_ROW_X, {20'h7ffff, 20'h80000, 20'h7ffff});
		write_reg(apnt_pkg::REG_ROW_Y, {20'h80000, 20'h7ffff, 20'h12345});
		write_reg(apnt_pkg::REG_ROW_Z, {20'h00001, 20'h54321, 20'h80000});
		write_reg(apnt_pkg::REG_OFF_X, 60'h7fffffff);
		write_reg(apnt_pkg::REG_OFF_Y, 60'h80000000);
		write_reg(apnt_pkg::REG_OFF_Z, 60'hfffffff_ffffffff);
		for (int k = 0; k < 6; k++) begin
			rq = rand_req();
			rq.pok = 1'b1;
			rq.nok = 1'b1;
			send_request(rq);
		end
		drain();
		// singular: two equal rows
		write_reg(apnt_pkg::REG_ROW_X, {20'h01000, 20'h02000, 20'h03000});
		write_reg(apnt_pkg::REG_ROW_Y, {20'h01000, 20'h02000, 20'h03000});
		for (int k = 0; k < 4; k++) begin
			rq = rand_req();
			rq.nok = 1'b1;
			send_request(rq);
		end
		drain();
		write_reg(RegSpareB, 60'hfffffffffffffff);
		write_reg(RegSpareA, 60'h0);
	endtask

	task automatic test_random(input int n_items, input int s_pct, input int r_pct);
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		for (int k = 0; k < n_items; k++) begin
			if (k % 60 == 0) begin
				drain();
				random_matrix();
			end
			send_request(rand_req());
		end
		drain();
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		fork
			begin
				recv_hold = 1'b1;
				repeat (200) @(negedge clk);
				recv_hold = 1'b0;
			end
			for (int k = 0; k < 100; k++) send_request(rand_req());
		join
		drain();
	endtask

	initial begin
		errors = 0;
		cycles = 0;
		recv_hold = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		for (int i = 0; i < 3; i++) begin
			offs[i] = 0;
			for (int j = 0; j < 3; j++) lin[i][j] = (i == j) ? 32768 : 0;
		end
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_identity_corners();
		test_extreme_matrix();
		test_random(190, 24, 68);
		test_random(190, 68, 24);
		test_random(190, 0, 0);
		test_backpressure();
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/apnt_pkg.sv
rtl/affine_point_normal_transform_core.sv
bench/tb_affine_point_normal_transform_core.sv
